[rtl/core/playfair_digram_cipher_defines.svh]
// ----------------------------------------------------------------------------
// playfair digram cipher assertion macros
// shared assertion shorthands for the cipher core
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAM_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAM_CIPHER_DEFINES_SVH

// same-cycle implication, off during reset
`define PDC_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PDC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg
// types and constants shared by the playfair cipher core
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_FINAL = 2'd1;
  localparam logic [1:0] REQ_PAIR  = 2'd2;

  localparam logic [4:0] LETTER_I  = 5'd8;
  localparam logic [4:0] LETTER_J  = 5'd9;
  localparam logic [4:0] LETTER_Z  = 5'd25;
  localparam logic [4:0] SQ_CELLS  = 5'd25;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] key_char;
    letter_t    first_letter;
    letter_t    second_letter;
  } request_t;

  typedef struct packed {
    letter_t out_first;
    letter_t out_second;
    logic    status;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/pdc_lane.sv]
// ----------------------------------------------------------------------------
// pdc_lane
// one pair letter: normalizes it for the slot lookup, decodes its cell
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_lane (
  input  wire  pdc_pkg::letter_t letter,
  input  wire  pdc_pkg::cell_t   slot_cell,
  output pdc_pkg::letter_t       addr,
  output pdc_pkg::pos_t          pos
);

  pdc_pkg::cell_t  sq_idx;
  pdc_pkg::coord_t row;
  logic [4:0]      row_base;

  // saturate past z, fold j onto i
  always_comb begin
    addr = letter;
    if (letter > pdc_pkg::LETTER_Z) addr = pdc_pkg::LETTER_Z;
    if (addr == pdc_pkg::LETTER_J) addr = pdc_pkg::LETTER_I;
  end

  // cell to row and column, five cells a row
  always_comb begin
    sq_idx = (slot_cell < pdc_pkg::SQ_CELLS) ? slot_cell : '0;
    if (sq_idx >= 5'd20)      row = 3'd4;
    else if (sq_idx >= 5'd15) row = 3'd3;
    else if (sq_idx >= 5'd10) row = 3'd2;
    else if (sq_idx >= 5'd5)  row = 3'd1;
    else                      row = 3'd0;
    row_base = ({2'b00, row} << 2) + {2'b00, row};
    pos.row  = row;
    pos.col  = 3'(sq_idx - row_base);
  end

endmodule

`default_nettype wire

[rtl/core/pdc_merge.sv]
// ----------------------------------------------------------------------------
// pdc_merge
// combines both lane positions by the playfair rules into two square cells
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_merge (
  input  wire  pdc_pkg::pos_t pos_a,
  input  wire  pdc_pkg::pos_t pos_b,
  input  wire                 direction,
  output pdc_pkg::cell_t      cell_a,
  output pdc_pkg::cell_t      cell_b
);

  pdc_pkg::pos_t out_a;
  pdc_pkg::pos_t out_b;

  function automatic pdc_pkg::coord_t step(input pdc_pkg::coord_t v, input logic back);
    pdc_pkg::coord_t r;
    if (back) r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    else      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    return r;
  endfunction

  function automatic pdc_pkg::cell_t to_cell(input pdc_pkg::pos_t p);
    logic [4:0] r;
    r = {2'b00, p.row};
    return (r << 2) + r + {2'b00, p.col};
  endfunction

  always_comb begin
    out_a = pos_a;
    out_b = pos_b;
    if (pos_a.row == pos_b.row) begin
      out_a.col = step(pos_a.col, direction);
      out_b.col = step(pos_b.col, direction);
    end else if (pos_a.col == pos_b.col) begin
      out_a.row = step(pos_a.row, direction);
      out_b.row = step(pos_b.row, direction);
    end else begin
      // rectangle corners swap columns
      out_a.col = pos_b.col;
      out_b.col = pos_a.col;
    end
  end

  assign cell_a = to_cell(out_a);
  assign cell_b = to_cell(out_b);

endmodule

`default_nettype wire

[rtl/core/playfair_digram_cipher.sv]
// ----------------------------------------------------------------------------
// playfair_digram_cipher
// playfair 5x5 engine: builds the key square from key bytes, then
// encrypts or decrypts letter pairs with two lookup lanes and a merge stage
// ----------------------------------------------------------------------------
// a pair item's result strobe follows the slot read and square read registers;
// busy covers the square read, and a new item is taken while a result is shown
// key bytes never raise busy; a first finalize holds busy, one letter a cycle
// a pair before finalize gives a status-only result in the cycle after acceptance
// rst is synchronous: empty square, no letters placed, encrypt direction
// results cannot be stalled; done marks each result for exactly one cycle
`default_nettype none
`include "playfair_digram_cipher_defines.svh"

module playfair_digram_cipher (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  pdc_pkg::request_t request,
  output logic               done,
  output pdc_pkg::result_t   result,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire                cfg_data
);

  // control states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;  // slot data registered, square read issued
  localparam logic [2:0] S_DONE = 3'd2;  // square data registered, result shown
  localparam logic [2:0] S_ERR  = 3'd3;  // not-ready status shown
  localparam logic [2:0] S_FILL = 3'd4;  // finalize walks the alphabet

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam int         ALPHA        = 26;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [4:0]       fill_count;
  logic [4:0]       fill_count_next;
  logic             square_ready;
  logic             square_ready_next;
  logic [ALPHA-1:0] slot_valid;
  logic [ALPHA-1:0] slot_valid_next;
  pdc_pkg::letter_t fill_ctr;
  pdc_pkg::letter_t fill_ctr_next;
  logic             cipher_direction;

  // key square and letter-to-cell map
  pdc_pkg::letter_t square_mem [25];
  pdc_pkg::cell_t   slot_mem   [ALPHA];
  pdc_pkg::cell_t   slot_rd_a;
  pdc_pkg::cell_t   slot_rd_b;
  pdc_pkg::letter_t sq_rd_a;
  pdc_pkg::letter_t sq_rd_b;

  logic             accept;
  logic             key_item;
  logic             key_is_letter;
  pdc_pkg::letter_t key_letter;
  logic             restart;
  pdc_pkg::letter_t place_letter;
  logic             place_req;
  logic             place_en;
  logic [ALPHA-1:0] valid_eff;
  logic [4:0]       fill_eff;

  pdc_pkg::letter_t lane_addr_a;
  pdc_pkg::letter_t lane_addr_b;
  pdc_pkg::pos_t    pos_a;
  pdc_pkg::pos_t    pos_b;
  pdc_pkg::cell_t   cell_a;
  pdc_pkg::cell_t   cell_b;

  // upper-case the byte, keep letters only, fold j onto i
  function automatic logic [5:0] decode_key(input logic [7:0] ch);
    logic [7:0]       up;
    logic [7:0]       diff;
    logic             ok;
    pdc_pkg::letter_t l;
    up = (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ? ch - CASE_OFFSET : ch;
    ok = (up >= CHAR_UPPER_A) && (up <= CHAR_UPPER_Z);
    diff = up - CHAR_UPPER_A;
    l = diff[4:0];
    if (l == pdc_pkg::LETTER_J) l = pdc_pkg::LETTER_I;
    return {ok, l};
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state == S_LOOK) || (state == S_FILL);
  assign cfg_ready = 1'b1;

  assign {key_is_letter, key_letter} = decode_key(request.key_char);
  assign key_item = accept && (request.req_type == pdc_pkg::REQ_KEY) && key_is_letter;

  // a letter after a finished square starts a new key
  assign restart   = key_item && square_ready;
  assign valid_eff = restart ? '0 : slot_valid;
  assign fill_eff  = restart ? '0 : fill_count;

  // one shared placement path for key bytes and the finalize walk
  assign place_letter = (state == S_FILL) ? fill_ctr : key_letter;
  assign place_req    = key_item || ((state == S_FILL) && (fill_ctr != pdc_pkg::LETTER_J));
  assign place_en     = place_req && !valid_eff[place_letter] &&
                        (fill_eff < pdc_pkg::SQ_CELLS);

  always_comb begin
    slot_valid_next = valid_eff;
    if (place_en) slot_valid_next[place_letter] = 1'b1;
    fill_count_next = place_en ? fill_eff + 5'd1 : fill_eff;
  end

  always_comb begin
    square_ready_next = square_ready;
    fill_ctr_next     = fill_ctr;
    if (restart) square_ready_next = 1'b0;
    if (state == S_FILL) begin
      fill_ctr_next = fill_ctr + 5'd1;
      if (fill_ctr == pdc_pkg::LETTER_Z) square_ready_next = 1'b1;
    end else if (accept && (request.req_type == pdc_pkg::REQ_FINAL)) begin
      fill_ctr_next = '0;
    end
  end

  // a new item can enter while a result is shown
  always_comb begin
    state_next = state;
    unique case (state) inside
      S_IDLE, S_DONE, S_ERR: begin
        state_next = S_IDLE;
        if (accept) begin
          case (request.req_type)
            pdc_pkg::REQ_PAIR:  state_next = square_ready ? S_LOOK : S_ERR;
            pdc_pkg::REQ_FINAL: state_next = square_ready ? S_IDLE : S_FILL;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        state_next = S_DONE;
      end
      S_FILL: begin
        if (fill_ctr == pdc_pkg::LETTER_Z) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      fill_count       <= '0;
      square_ready     <= 1'b0;
      slot_valid       <= '0;
      fill_ctr         <= '0;
      cipher_direction <= 1'b0;
    end else begin
      state        <= state_next;
      fill_count   <= fill_count_next;
      square_ready <= square_ready_next;
      slot_valid   <= slot_valid_next;
      fill_ctr     <= fill_ctr_next;
      if (cfg_valid && cfg_ready) cipher_direction <= cfg_data;
    end
  end

  // memories: one write port each, two registered read ports
  always_ff @(posedge clk) begin
    if (place_en) begin
      square_mem[fill_eff]     <= place_letter;
      slot_mem[place_letter]   <= fill_eff;
    end
    slot_rd_a <= slot_mem[lane_addr_a];
    slot_rd_b <= slot_mem[lane_addr_b];
    sq_rd_a   <= square_mem[cell_a];
    sq_rd_b   <= square_mem[cell_b];
  end

  // one lane per pair letter
  pdc_lane u_lane_a (
    .letter    (request.first_letter),
    .slot_cell (slot_rd_a),
    .addr      (lane_addr_a),
    .pos       (pos_a)
  );

  pdc_lane u_lane_b (
    .letter    (request.second_letter),
    .slot_cell (slot_rd_b),
    .addr      (lane_addr_b),
    .pos       (pos_b)
  );

  // rules applied to both positions, giving the square cells to read
  pdc_merge u_merge (
    .pos_a     (pos_a),
    .pos_b     (pos_b),
    .direction (cipher_direction),
    .cell_a    (cell_a),
    .cell_b    (cell_b)
  );

  // result drive
  assign done              = (state == S_DONE) || (state == S_ERR);
  assign result.out_first  = (state == S_DONE) ? sq_rd_a : '0;
  assign result.out_second = (state == S_DONE) ? sq_rd_b : '0;
  assign result.status     = (state == S_ERR) ? pdc_pkg::STATUS_NOT_READY
                                              : pdc_pkg::STATUS_OK;

  `PDC_ASSERT_SAME(a_fill_bound, clk, rst, 1'b1, fill_count <= pdc_pkg::SQ_CELLS, "fill count past square size")
  `PDC_ASSERT_SAME(a_done_ready, clk, rst, state == S_DONE, square_ready, "pair result from unfinished square")
  `PDC_ASSERT_NEXT(a_err_result, clk, rst, accept && (request.req_type == pdc_pkg::REQ_PAIR) && !square_ready, done && (result.status == pdc_pkg::STATUS_NOT_READY), "early pair without error status")
  `PDC_ASSERT_NEXT(a_fill_full, clk, rst, (state == S_FILL) && (fill_ctr == pdc_pkg::LETTER_Z), square_ready && (fill_count == pdc_pkg::SQ_CELLS), "finalize left square incomplete")

endmodule

`default_nettype wire

[test/playfair_digram_cipher_tb.sv]
// ----------------------------------------------------------------------------
// playfair_digram_cipher_tb
// drives key bytes, finalize and letter-pair items into the cipher core in
// keyed sessions under both directions, predicts every pair result from a
// local copy of the key square and checks each strobed result in order
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digram_cipher_tb;

  // request code with no operation behind it, the core drops it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // ascii bounds for key byte handling
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;
  localparam logic [7:0] LOWER_A  = 8'h61;
  localparam logic [7:0] LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam int ITEM_TARGET   = 1450;
  // quiet time after drain, longer than a finalize walk of the alphabet
  localparam int SETTLE_CYCLES = 32;
  // several times over the longest sender gap, a finalize walk and the settle time
  localparam int IDLE_LIMIT    = 2000;

  // --------------------------------------------------------------------------
  // key square tracker and pair result checker
  // --------------------------------------------------------------------------
  class playfair_scoreboard;
    pdc_pkg::letter_t square[25];
    logic [5:0]       slot[26];      // bit 5 placed, bits 4..0 cell index
    int               filled;
    bit               complete;
    bit               decrypt;
    pdc_pkg::result_t expected_q[$];
    int               errors;

    function new();
      foreach (square[i]) square[i] = '0;
      restart_key();
      decrypt = 1'b0;
      errors  = 0;
    endfunction

    function void restart_key();
      foreach (slot[i]) slot[i] = '0;
      filled   = 0;
      complete = 1'b0;
    endfunction

    function void place(pdc_pkg::letter_t l);
      if (slot[l][5] || filled >= int'(pdc_pkg::SQ_CELLS)) return;
      square[filled] = l;
      slot[l] = {1'b1, 5'(filled)};
      filled++;
    endfunction

    function pdc_pkg::letter_t fold(pdc_pkg::letter_t l);
      if (l > pdc_pkg::LETTER_Z) l = pdc_pkg::LETTER_Z;
      if (l == pdc_pkg::LETTER_J) l = pdc_pkg::LETTER_I;
      return l;
    endfunction

    function int cell_of(pdc_pkg::letter_t l);
      return (slot[l][4:0] < pdc_pkg::SQ_CELLS) ? int'(slot[l][4:0]) : 0;
    endfunction

    // called for every accepted item
    function void note_request(pdc_pkg::request_t r);
      logic [7:0]       ch;
      pdc_pkg::letter_t l;
      pdc_pkg::result_t e;
      int               pa, pb, r1, c1, r2, c2, stride;
      case (r.req_type)
        pdc_pkg::REQ_KEY: begin
          ch = r.key_char;
          if (ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CASE_GAP;
          if (ch >= UPPER_A && ch <= UPPER_Z) begin
            if (complete) restart_key();
            l = pdc_pkg::letter_t'(ch - UPPER_A);
            if (l == pdc_pkg::LETTER_J) l = pdc_pkg::LETTER_I;
            place(l);
          end
        end
        pdc_pkg::REQ_FINAL: begin
          if (!complete) begin
            for (int i = 0; i < 26; i++)
              if (pdc_pkg::letter_t'(i) != pdc_pkg::LETTER_J) place(pdc_pkg::letter_t'(i));
            complete = 1'b1;
          end
        end
        pdc_pkg::REQ_PAIR: begin
          if (!complete) begin
            e.out_first  = '0;
            e.out_second = '0;
            e.status     = pdc_pkg::STATUS_NOT_READY;
          end else begin
            pa = cell_of(fold(r.first_letter));
            pb = cell_of(fold(r.second_letter));
            r1 = pa / 5;
            c1 = pa % 5;
            r2 = pb / 5;
            c2 = pb % 5;
            stride = decrypt ? 4 : 1;
            if (r1 == r2) begin
              e.out_first  = square[r1 * 5 + (c1 + stride) % 5];
              e.out_second = square[r2 * 5 + (c2 + stride) % 5];
            end else if (c1 == c2) begin
              e.out_first  = square[((r1 + stride) % 5) * 5 + c1];
              e.out_second = square[((r2 + stride) % 5) * 5 + c2];
            end else begin
              e.out_first  = square[r1 * 5 + c2];
              e.out_second = square[r2 * 5 + c1];
            end
            e.status = pdc_pkg::STATUS_OK;
          end
          expected_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    // called for every strobed result
    function void check_result(pdc_pkg::result_t got);
      pdc_pkg::result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: first %0d second %0d status %0d",
                   got.out_first, got.out_second, got.status);
        return;
      end
      e = expected_q.pop_front();
      if (got.out_first !== e.out_first || got.out_second !== e.out_second ||
          got.status !== e.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected first %0d second %0d status %0d, got %0d %0d %0d",
                   e.out_first, e.out_second, e.status,
                   got.out_first, got.out_second, got.status);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut and clock
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  pdc_pkg::request_t request;
  logic              done;
  pdc_pkg::result_t  result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;

  playfair_digram_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  playfair_scoreboard sb = new();

  int items_sent  = 0;
  int idle_cycles = 0;
  bit no_idle     = 1'b0;   // set for phases that run back to back

  // --------------------------------------------------------------------------
  // monitor: sample handshakes at the edge, results before new items
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_request(request);
      if (cfg_valid && cfg_ready) sb.decrypt = cfg_data;
      // watchdog counter, cleared by any handshake or result
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL playfair_digram_cipher");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // mostly legal letters, some out-of-range codes that saturate to z
  function automatic pdc_pkg::letter_t pick_letter();
    if ($urandom_range(0, 99) < 85) return pdc_pkg::letter_t'($urandom_range(0, 25));
    return pdc_pkg::letter_t'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] letter_byte(pdc_pkg::letter_t l);
    return UPPER_A + 8'(l) + ($urandom_range(0, 1) ? CASE_GAP : 8'h00);
  endfunction

  function automatic logic [7:0] non_letter_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while ((b >= UPPER_A && b <= UPPER_Z) || (b >= LOWER_A && b <= LOWER_Z));
    return b;
  endfunction

  // keyword bytes: letters of either case, extra j's, and raw noise bytes
  function automatic logic [7:0] pick_key_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return letter_byte(pdc_pkg::letter_t'($urandom_range(0, 25)));
    if (roll < 75) return letter_byte(pdc_pkg::LETTER_J);
    return 8'($urandom);
  endfunction

  // unused fields carry random bits so every input bit toggles
  function automatic pdc_pkg::request_t make_request(logic [1:0] kind, logic [7:0] ch,
                                                     pdc_pkg::letter_t a,
                                                     pdc_pkg::letter_t b);
    pdc_pkg::request_t r;
    r.req_type      = kind;
    r.key_char      = ch;
    r.first_letter  = a;
    r.second_letter = b;
    return r;
  endfunction

  function automatic pdc_pkg::request_t random_pair();
    return make_request(pdc_pkg::REQ_PAIR, 8'($urandom), pick_letter(), pick_letter());
  endfunction

  function automatic pdc_pkg::request_t random_final();
    return make_request(pdc_pkg::REQ_FINAL, 8'($urandom), pdc_pkg::letter_t'($urandom),
                        pdc_pkg::letter_t'($urandom));
  endfunction

  function automatic pdc_pkg::request_t random_key(logic [7:0] ch);
    return make_request(pdc_pkg::REQ_KEY, ch, pdc_pkg::letter_t'($urandom),
                        pdc_pkg::letter_t'($urandom));
  endfunction

  // hold start until the core takes the item, then maybe pause
  task automatic issue(pdc_pkg::request_t r);
    int gap;
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    if (r.req_type != REQ_UNUSED) items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending, let every result arrive and the core go quiet
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(bit decrypt);
    cfg_valid <= 1'b1;
    cfg_data  <= decrypt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one keyword, finalize, then a run of pairs with some noise mixed in
  task automatic run_session();
    int               kind, roll;
    pdc_pkg::letter_t alpha[25];
    pdc_pkg::letter_t tmp;
    int               k, j;
    kind = $urandom_range(0, 19);
    if (kind == 1) begin
      // all 25 letters in shuffled order, finalize then adds nothing
      k = 0;
      for (int i = 0; i < 26; i++)
        if (pdc_pkg::letter_t'(i) != pdc_pkg::LETTER_J) begin
          alpha[k] = pdc_pkg::letter_t'(i);
          k++;
        end
      for (int i = 24; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = alpha[i];
        alpha[i] = alpha[j];
        alpha[j] = tmp;
      end
      foreach (alpha[i]) issue(random_key(letter_byte(alpha[i])));
    end else if (kind != 0) begin
      // kind 0 leaves the key empty
      repeat ($urandom_range(1, 20)) issue(random_key(pick_key_byte()));
    end
    // broken session: pairs sent before the square is finished
    if ($urandom_range(0, 9) == 0) begin
      issue(random_key(letter_byte(pdc_pkg::letter_t'(pick_letter() % 26))));
      repeat ($urandom_range(1, 4)) issue(random_pair());
    end
    issue(random_final());
    repeat ($urandom_range(30, 120)) begin
      roll = $urandom_range(0, 99);
      if (roll < 88) issue(random_pair());
      else if (roll < 91)
        issue(make_request(REQ_UNUSED, 8'($urandom), pdc_pkg::letter_t'($urandom),
                           pdc_pkg::letter_t'($urandom)));
      else if (roll < 94) issue(random_final());
      else if (roll < 97) issue(random_key(non_letter_byte()));
      else begin
        // key letter after a finished square starts a new key
        issue(random_key(letter_byte(pdc_pkg::letter_t'($urandom_range(0, 25)))));
        repeat ($urandom_range(0, 3)) issue(random_key(pick_key_byte()));
        repeat ($urandom_range(1, 2)) issue(random_pair());
        issue(random_final());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    bit dir;
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_direction(1'b0);

    // directed: pair before any key, with out-of-range first letter
    issue(make_request(pdc_pkg::REQ_PAIR, 8'h00, 5'd31, 5'd0));
    issue(make_request(REQ_UNUSED, 8'hFF, 5'd31, 5'd31));
    // keyword "pLJiZp" with noise bytes; square starts P L I Z then A B C ...
    issue(random_key(8'h70));   // lower p
    issue(random_key(8'h4C));   // L
    issue(random_key(8'h21));   // punctuation
    issue(random_key(8'h4A));   // J folds to I
    issue(random_key(8'h69));   // i repeats
    issue(random_key(8'h00));
    issue(random_key(8'hFF));
    issue(random_key(8'h5A));   // Z
    issue(random_key(8'h70));   // p repeats
    issue(random_key(8'h40));   // just below A
    issue(random_key(8'h5B));   // just above Z
    issue(random_final());
    issue(random_final());      // second finalize leaves the square alone
    // rows: P L I Z A / B C D E F / G H K M N / O Q R S T / U V W X Y
    issue(make_request(pdc_pkg::REQ_PAIR, 8'h00, 5'd15, 5'd0));    // same row
    issue(make_request(pdc_pkg::REQ_PAIR, 8'h00, 5'd11, 5'd16));   // same column
    issue(make_request(pdc_pkg::REQ_PAIR, 8'h00, 5'd3, 5'd19));    // rectangle
    issue(make_request(pdc_pkg::REQ_PAIR, 8'hFF, pdc_pkg::LETTER_J, 5'd31));
    issue(make_request(pdc_pkg::REQ_PAIR, 8'h00, 5'd26, pdc_pkg::LETTER_Z)); // same letter
    issue(make_request(pdc_pkg::REQ_PAIR, 8'h00, 5'd0, 5'd0));
    issue(random_key(8'h60));   // non-letter after finish, no restart
    issue(make_request(pdc_pkg::REQ_PAIR, 8'h00, 5'd4, 5'd20));
    issue(random_key(8'h6B));   // letter after finish restarts the key
    issue(make_request(pdc_pkg::REQ_PAIR, 8'h00, 5'd4, 5'd20));
    issue(random_final());
    drain();

    // random phases, direction changed only while the core is quiet
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) dir = 1'b1;
      else if (phase == 1) dir = 1'b0;
      else dir = 1'($urandom_range(0, 1));
      write_direction(dir);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 2)) run_session();
      drain();
      phase++;
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("PASS playfair_digram_cipher");
    else
      $display("FAIL playfair_digram_cipher");
    $finish;
  end

endmodule

`default_nettype wire
